### rtl/egbl_pkg.sv
`timescale 1ns / 1ps

package egbl_pkg;

	localparam int ADDR_W     = 16;                 // post store index width
	localparam int POST_DEPTH = 2 ** ADDR_W;
	localparam int POST_W     = 16;
	localparam int LON_W      = 31;
	localparam int LAT_W      = 30;
	localparam int PPD_W      = 28;
	localparam int LINES_W    = 9;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;
	localparam int HEIGHT_W   = 24;
	localparam int DIV_STEPS  = 24;                 // quotient bits
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	localparam logic [POST_W-1:0]   VOID_POST    = 16'hFFFF;
	localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT = 24'd8388352;
	localparam logic [16:0]         ONE_Q16      = 17'd65536;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CORNER_LON = 3'd0,
		CFG_CORNER_LAT = 3'd1,
		CFG_LON_PPD    = 3'd2,
		CFG_LAT_PPD    = 3'd3,
		CFG_LON_LINES  = 3'd4,
		CFG_LAT_POINTS = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MUL_LON,
		MUL_LAT,
		MUL_WT,
		MUL_HW
	} mul_sel_t;

	// controller -> datapath
	typedef struct packed {
		logic       load_post;
		logic       start_query;
		logic       prod_en;
		mul_sel_t   mul_sel;
		logic       chk_lon;
		logic       chk_lat;
		logic       base_en;
		logic       rd_en;
		logic [1:0] k;
		logic       hw_en;
		logic       acc_en;
		logic       div_init;
		logic       div_step;
		logic       out_load;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic fail;
		logic den_zero;
	} dp_sts_t;

endpackage

### rtl/egbl_datapath.sv
`timescale 1ns / 1ps

module egbl_datapath import egbl_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic [ADDR_W-1:0]            post_index,
	input  logic [POST_W-1:0]            post_word,
	input  logic signed [LON_W-1:0]      query_lon,
	input  logic signed [LAT_W-1:0]      query_lat,
	input  dp_cmd_t                      cmd,
	output dp_sts_t                      sts,
	output logic signed [HEIGHT_W-1:0]   height,
	output logic                         no_data
);

	logic signed [LON_W-1:0] corner_lon_q;
	logic signed [LAT_W-1:0] corner_lat_q;
	logic [PPD_W-1:0]        lon_ppd_q, lat_ppd_q;
	logic [LINES_W-1:0]      lon_lines_q, lat_points_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_lon_q <= '0;
			corner_lat_q <= '0;
			lon_ppd_q    <= 28'd65536;
			lat_ppd_q    <= 28'd65536;
			lon_lines_q  <= 9'd2;
			lat_points_q <= 9'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CORNER_LON: corner_lon_q <= cfg_data[LON_W-1:0];
				CFG_CORNER_LAT: corner_lat_q <= cfg_data[LAT_W-1:0];
				CFG_LON_PPD:    lon_ppd_q    <= cfg_data[PPD_W-1:0];
				CFG_LAT_PPD:    lat_ppd_q    <= cfg_data[PPD_W-1:0];
				CFG_LON_LINES:  lon_lines_q  <= cfg_data[LINES_W-1:0];
				CFG_LAT_POINTS: lat_points_q <= cfg_data[LINES_W-1:0];
				default: ;
			endcase
		end
	end

	// post store, single port
	logic [POST_W-1:0] mem [POST_DEPTH];
	logic [POST_W-1:0] rdata_q;
	logic [ADDR_W-1:0] base_q, rd_addr;

	assign rd_addr = base_q
		+ (cmd.k[1] ? {{(ADDR_W-LINES_W){1'b0}}, lat_points_q} : '0)
		+ {{(ADDR_W-1){1'b0}}, cmd.k[0]};

	always_ff @(posedge clk) begin
		if (cmd.load_post)
			mem[post_index] <= post_word;
		if (cmd.rd_en)
			rdata_q <= mem[rd_addr];
	end

	// coordinate offsets
	logic signed [31:0] lon_diff_q, lat_diff_q;
	always_ff @(posedge clk) begin
		if (cmd.start_query) begin
			lon_diff_q <= {query_lon[LON_W-1], query_lon} - {corner_lon_q[LON_W-1], corner_lon_q};
			lat_diff_q <= {{2{query_lat[LAT_W-1]}}, query_lat}
				- {{2{corner_lat_q[LAT_W-1]}}, corner_lat_q};
		end
	end

	// shared multiplier
	logic [16:0]        wx1_q, wy1_q, wx0, wy0, wx_sel, wy_sel;
	logic [32:0]        wt_q;
	logic signed [15:0] h;
	logic signed [33:0] mul_a;
	logic signed [28:0] mul_b;
	logic signed [62:0] mul_res, prod_q;

	assign wx0    = ONE_Q16 - wx1_q;
	assign wy0    = ONE_Q16 - wy1_q;
	assign wx_sel = cmd.k[1] ? wx1_q : wx0;
	assign wy_sel = cmd.k[0] ? wy1_q : wy0;
	assign h      = rdata_q[15] ? -$signed({1'b0, rdata_q[14:0]}) : $signed({1'b0, rdata_q[14:0]});

	always_comb begin
		case (cmd.mul_sel)
			MUL_LON: begin
				mul_a = {{2{lon_diff_q[31]}}, lon_diff_q};
				mul_b = {1'b0, lon_ppd_q};
			end
			MUL_LAT: begin
				mul_a = {{2{lat_diff_q[31]}}, lat_diff_q};
				mul_b = {1'b0, lat_ppd_q};
			end
			MUL_WT: begin
				mul_a = {17'b0, wx_sel};
				mul_b = {12'b0, wy_sel};
			end
			default: begin
				mul_a = {1'b0, wt_q};
				mul_b = {{13{h[15]}}, h};
			end
		endcase
	end

	assign mul_res = mul_a * mul_b;

	// axis check on the product held in prod_q
	logic [LINES_W-1:0] lines, lines_m1;
	logic [37:0]        x;
	logic               axis_bad, axis_edge;
	logic [7:0]         start;
	logic [16:0]        far_w;

	assign lines     = cmd.chk_lat ? lat_points_q : lon_lines_q;
	assign lines_m1  = lines - 9'd1;
	assign x         = prod_q[59:22];
	assign axis_bad  = (lines < 9'd2) || prod_q[62] || (x > {13'b0, lines_m1, 16'b0});
	assign axis_edge = ({1'b0, x[23:16]} == lines_m1);
	assign start     = axis_edge ? 8'(lines - 9'd2) : x[23:16];
	assign far_w     = axis_edge ? ONE_Q16 : {1'b0, x[15:0]};

	logic               fail_q, null_q, neg_q;
	logic signed [47:0] num_q;
	logic [32:0]        den_q;
	logic [7:0]         x0_q, y0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_q <= 1'b0;
		end else if (cmd.start_query) begin
			fail_q <= 1'b0;
		end else if ((cmd.chk_lon || cmd.chk_lat) && axis_bad) begin
			fail_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prod_en || cmd.hw_en)
			prod_q <= mul_res;
		if (cmd.hw_en)
			null_q <= (rdata_q == VOID_POST);
		if (cmd.rd_en)
			wt_q <= mul_res[32:0];
		if (cmd.chk_lon) begin
			x0_q  <= start;
			wx1_q <= far_w;
		end
		if (cmd.chk_lat) begin
			y0_q  <= start;
			wy1_q <= far_w;
		end
		if (cmd.base_en)
			base_q <= ADDR_W'({8'b0, x0_q} * {8'b0, lat_points_q} + {9'b0, y0_q});
		if (cmd.start_query) begin
			num_q <= '0;
			den_q <= '0;
		end else if (cmd.acc_en && !null_q) begin
			num_q <= num_q + prod_q[47:0];
			den_q <= den_q + wt_q;
		end
	end

	assign sts.fail     = fail_q;
	assign sts.den_zero = (den_q == '0);

	// restoring divide: (|num|*512 + den) / (2*den), one quotient bit a cycle
	logic [46:0] mag;
	logic [56:0] numer;
	logic [33:0] rem_q, dvs_q;
	logic [23:0] quo_q;
	logic [34:0] trial;
	logic        fits;

	assign mag   = num_q[47] ? 47'(-num_q) : num_q[46:0];
	assign numer = {1'b0, mag, 9'b0} + {24'b0, den_q};
	assign trial = {rem_q, quo_q[23]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= {1'b0, numer[56:24]};
			quo_q <= numer[23:0];
			dvs_q <= {den_q, 1'b0};
			neg_q <= num_q[47];
		end else if (cmd.div_step) begin
			rem_q <= fits ? 34'(trial - {1'b0, dvs_q}) : trial[33:0];
			quo_q <= {quo_q[22:0], fits};
		end
	end

	logic [HEIGHT_W-1:0] q_clamped;
	assign q_clamped = (quo_q > HEIGHT_LIMIT) ? HEIGHT_LIMIT : quo_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			no_data <= sts.den_zero;
			height  <= sts.den_zero ? '0 : (neg_q ? -$signed(q_clamped) : $signed(q_clamped));
		end
	end

endmodule

### rtl/egbl_ctrl.sv
`timescale 1ns / 1ps

module egbl_ctrl import egbl_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  logic    opcode,
	output logic    out_valid,
	input  logic    out_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_LONMUL, S_LATMUL, S_LATCHK, S_BASE,
		S_RD, S_HM, S_ACC, S_DIVSET, S_DIV, S_OUT
	} state_t;

	state_t               state_q;
	logic [1:0]           k_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 out_valid_q;
	logic                 in_acc, out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		cmd             = '0;
		cmd.mul_sel     = MUL_LON;
		cmd.k           = k_q;
		cmd.load_post   = in_acc && !opcode;
		cmd.start_query = in_acc && opcode;
		unique case (state_q)
			S_LONMUL: cmd.prod_en = 1'b1;
			S_LATMUL: begin
				cmd.prod_en = 1'b1;
				cmd.mul_sel = MUL_LAT;
				cmd.chk_lon = 1'b1;
			end
			S_LATCHK: cmd.chk_lat = 1'b1;
			S_BASE:   cmd.base_en = 1'b1;
			S_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.mul_sel = MUL_WT;
			end
			S_HM: begin
				cmd.hw_en   = 1'b1;
				cmd.mul_sel = MUL_HW;
			end
			S_ACC:    cmd.acc_en   = 1'b1;
			S_DIVSET: cmd.div_init = !sts.den_zero;
			S_DIV:    cmd.div_step = 1'b1;
			S_OUT:    cmd.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE:   if (in_acc && opcode) state_q <= S_LONMUL;
				S_LONMUL: state_q <= S_LATMUL;
				S_LATMUL: state_q <= S_LATCHK;
				S_LATCHK: state_q <= S_BASE;
				S_BASE: begin
					k_q     <= '0;
					state_q <= sts.fail ? S_OUT : S_RD;
				end
				S_RD:     state_q <= S_HM;
				S_HM:     state_q <= S_ACC;
				S_ACC: begin
					k_q     <= k_q + 2'd1;
					state_q <= (k_q == 2'd3) ? S_DIVSET : S_RD;
				end
				S_DIVSET: begin
					cnt_q   <= '0;
					state_q <= sts.den_zero ? S_OUT : S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1))
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/elevation_grid_bilinear_lookup.sv
`timescale 1ns / 1ps

// Elevation grid with bilinear lookup.
// Input channel (in_valid/in_stall): opcode 0 writes post_word into the post
// store at post_index; opcode 1 queries the height at query_lon/query_lat.
// A transaction completes when valid is high and stall is low.
// Loads can stream back to back; they give no result.
// A query holds in_stall high while it runs, until its result is loaded into
// the output register. Outside the grid it skips the post reads and the
// divide, and with all four posts null it skips the divide. The run is set
// by two coordinate multiplies on the shared multiplier, four post reads
// through the single store port (each a read with weight multiply, a height
// multiply and an accumulate) and a 24-step restoring divide.
// Output channel (out_valid/out_stall): one transaction per query carrying
// height (Q16.8) and no_data. The result waits in an output register while
// out_stall is high; the block takes new loads meanwhile, and a following
// query runs but holds its result until the register frees.
// Reset clears the controller and loads the register defaults; the post store
// is not cleared, so only written posts may be queried. Configuration writes
// (cfg_we) take effect at the next edge; the user must make them only while
// idle: the block itself does not enforce this.

module elevation_grid_bilinear_lookup import egbl_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       opcode,
	input  logic [ADDR_W-1:0]          post_index,
	input  logic [POST_W-1:0]          post_word,
	input  logic signed [LON_W-1:0]    query_lon,
	input  logic signed [LAT_W-1:0]    query_lat,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [HEIGHT_W-1:0] height,
	output logic                       no_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencing: one query at a time
	egbl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// registers, post store, multiplier, accumulators, divider, result regs
	egbl_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.post_index (post_index),
		.post_word  (post_word),
		.query_lon  (query_lon),
		.query_lat  (query_lat),
		.cmd        (cmd),
		.sts        (sts),
		.height     (height),
		.no_data    (no_data)
	);

	// a no-data result always carries zero height
	a_nodata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_data |-> height == '0)
		else $error("no_data result with nonzero height");

	// a query blocks the input on the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && opcode |=> in_stall)
		else $error("input not stalled after query");

	// a load never produces a result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !opcode && !out_valid |=> !out_valid)
		else $error("result appeared after a load");

	// the result register is only loaded while it is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !out_valid || !out_stall)
		else $error("result overwritten while stalled");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import egbl_pkg::*;

	localparam bit OP_LOAD  = 1'b0;
	localparam bit OP_QUERY = 1'b1;
	localparam longint LON_MAX = 64'd754974720;
	localparam longint LAT_MAX = 64'd377487360;
	localparam longint PPD_MAX = 64'd235929600;
	localparam int IDLE_LIMIT  = 4000;  // cycles without any transaction
	localparam int DRAIN_WAIT  = 60;    // extra wait after the last result is checked
	localparam int RANDOM_OPS  = 85;    // per configuration phase

	typedef struct {
		logic signed [HEIGHT_W-1:0] height;
		logic                       no_data;
	} height_rec_t;

	typedef struct {
		bit                         op;
		logic [ADDR_W-1:0]          idx;
		logic [POST_W-1:0]          word;
		longint                     lon;
		longint                     lat;
		bit                         typed;   // expected value given in the row
		logic signed [HEIGHT_W-1:0] height;
		logic                       no_data;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic opcode = 1'b0;
	logic [ADDR_W-1:0] post_index = '0;
	logic [POST_W-1:0] post_word = '0;
	logic signed [LON_W-1:0] query_lon = '0;
	logic signed [LAT_W-1:0] query_lat = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [HEIGHT_W-1:0] height;
	logic no_data;

	elevation_grid_bilinear_lookup dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Shadow of the block: register copy and post store
	// ---------------------------------------------------------------
	logic signed [LON_W-1:0]   sh_corner_lon;
	logic signed [LAT_W-1:0]   sh_corner_lat;
	logic [PPD_W-1:0]          sh_lon_ppd;
	logic [PPD_W-1:0]          sh_lat_ppd;
	logic [LINES_W-1:0]        sh_lon_lines;
	logic [LINES_W-1:0]        sh_lat_points;
	logic [POST_W-1:0]         post_mem [POST_DEPTH];
	bit                        post_set [POST_DEPTH];

	height_rec_t heights_due[$];
	int mismatches = 0;
	int idle_cycles = 0;
	int burst_left = 0;

	// One axis: cell start and far weight (Q16). Zero when the point is outside.
	function automatic bit axis_cell(input longint diff, input longint ppd,
			input longint lines, output longint start, output longint far_w);
		longint prod;
		longint x;
		prod = diff * ppd;
		start = 0;
		far_w = 0;
		if (lines < 2 || prod < 0)
			return 1'b0;
		x = prod >> 22;
		if (x > ((lines - 1) << 16))
			return 1'b0;
		if ((x >> 16) == lines - 1) begin
			// top/right edge: step back one post, all weight on the far side
			start = lines - 2;
			far_w = 65536;
		end else begin
			start = x >> 16;
			far_w = x & 65535;
		end
		return 1'b1;
	endfunction

	// Returns 0 when the query would touch a post never written (not legal to send).
	function automatic bit interp_height(input longint lon, input longint lat,
			output height_rec_t r);
		longint x0, y0, wx1, wy1, wx0, wy0, base, den, num, mag, q, pts, hv;
		longint wts[4];
		longint offs[4];
		logic [ADDR_W-1:0] a;
		logic [POST_W-1:0] w;
		r.height = '0;
		r.no_data = 1'b1;
		if (!axis_cell(lon - longint'(sh_corner_lon), longint'(sh_lon_ppd),
				longint'(sh_lon_lines), x0, wx1))
			return 1'b1;
		if (!axis_cell(lat - longint'(sh_corner_lat), longint'(sh_lat_ppd),
				longint'(sh_lat_points), y0, wy1))
			return 1'b1;
		pts = longint'(sh_lat_points);
		wx0 = 65536 - wx1;
		wy0 = 65536 - wy1;
		base = x0 * pts + y0;
		offs = '{0, 1, pts, pts + 1};
		wts = '{wx0 * wy0, wx0 * wy1, wx1 * wy0, wx1 * wy1};
		den = 0;
		num = 0;
		for (int k = 0; k < 4; k++) begin
			a = ADDR_W'(base + offs[k]);
			if (!post_set[a])
				return 1'b0;
			w = post_mem[a];
			if (w == VOID_POST)
				continue;
			hv = longint'(w[14:0]);
			if (w[15])
				hv = -hv;
			den += wts[k];
			num += hv * wts[k];
		end
		if (den == 0)
			return 1'b1;
		mag = (num < 0) ? -num : num;
		q = (mag * 512 + den) / (2 * den);
		if (q > longint'(HEIGHT_LIMIT))
			q = longint'(HEIGHT_LIMIT);
		r.height = HEIGHT_W'((num < 0) ? -q : q);
		r.no_data = 1'b0;
		return 1'b1;
	endfunction

	task automatic note_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t mismatch: %s", $realtime, what);
	endtask

	// ---------------------------------------------------------------
	// Result side: stall pattern and compare against oldest expectation
	// ---------------------------------------------------------------
	int stall_mode = 0;
	int stall_left = 0;

	always @(posedge clk) begin
		height_rec_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (heights_due.size() == 0) begin
				note_mismatch($sformatf("result h=%0d nd=%0b with none pending",
					height, no_data));
			end else begin
				e = heights_due.pop_front();
				if (height !== e.height || no_data !== e.no_data)
					note_mismatch($sformatf("exp h=%0d nd=%0b got h=%0d nd=%0b",
						e.height, e.no_data, height, no_data));
			end
		end
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(20, 120);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= 1'($urandom_range(0, 1));
			default: out_stall <= ($urandom_range(0, 7) != 0);  // long stall runs
		endcase
	end

	// Watchdog: ends the run if nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ---------------------------------------------------------------
	// Input side
	// ---------------------------------------------------------------
	// Drive one transaction until taken, then update the shadow or expected queue.
	task automatic send_item(input stim_row_t s);
		height_rec_t r;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid   <= 1'b1;
		opcode     <= s.op;
		post_index <= s.idx;
		post_word  <= s.word;
		query_lon  <= LON_W'(s.lon);
		query_lat  <= LAT_W'(s.lat);
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (s.op == OP_LOAD) begin
			post_mem[s.idx] = s.word;
			post_set[s.idx] = 1'b1;
		end else if (s.typed) begin
			heights_due.push_back('{s.height, s.no_data});
		end else begin
			void'(interp_height(s.lon, s.lat, r));
			heights_due.push_back(r);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (heights_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_regs(input longint v[6]);
		for (int i = 0; i < 6; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= cfg_reg_t'(i);
			cfg_data  <= CFG_DATA_W'(v[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		sh_corner_lon = LON_W'(v[CFG_CORNER_LON]);
		sh_corner_lat = LAT_W'(v[CFG_CORNER_LAT]);
		sh_lon_ppd    = PPD_W'(v[CFG_LON_PPD]);
		sh_lat_ppd    = PPD_W'(v[CFG_LAT_PPD]);
		sh_lon_lines  = LINES_W'(v[CFG_LON_LINES]);
		sh_lat_points = LINES_W'(v[CFG_LAT_POINTS]);
	endtask

	function automatic logic [POST_W-1:0] rand_post_word();
		case ($urandom_range(0, 11))
			0, 1: return VOID_POST;
			2: return 16'h8000;      // negative zero
			default: return POST_W'($urandom);
		endcase
	endfunction

	function automatic longint rand_span(input longint lo, input longint hi);
		return lo + (longint'($urandom) % (hi - lo + 1));
	endfunction

	// Coordinate near the loaded part of one axis, sometimes exactly on a post line,
	// sometimes anywhere in the field range.
	function automatic longint pick_coord(input longint corner, input longint ppd,
			input longint cells, input longint fmax);
		longint extent, lo, hi, c;
		extent = (cells << 38) / ppd;
		case ($urandom_range(0, 19))
			0, 1, 2: c = rand_span(-fmax, fmax);
			3, 4, 5, 6: c = corner + (((longint'($urandom_range(0, cells))) << 38)
				+ ppd - 1) / ppd;
			default: begin
				lo = corner - extent / 8;
				hi = corner + extent + extent / 8;
				if (lo < -fmax) lo = -fmax;
				if (hi > fmax) hi = fmax;
				if (lo > hi) lo = hi;
				c = rand_span(lo, hi);
			end
		endcase
		if (c > fmax) c = fmax;
		if (c < -fmax) c = -fmax;
		return c;
	endfunction

	// Register set for each phase; loaded_cols is how many columns get posts.
	task automatic pick_phase(input int n, output longint v[6], output int loaded_cols);
		case (n)
			1: v = '{-LON_MAX, -LAT_MAX, PPD_MAX, PPD_MAX, 2, 3};
			2: v = '{LON_MAX, LAT_MAX, 1, 1, 256, 256};
			3: v = '{0, 0, 65536, 65536, 256, 2};
			4: v = '{rand_span(-LON_MAX, LON_MAX), rand_span(-LAT_MAX, LAT_MAX),
				1, PPD_MAX, 256, 3};
			default: v = '{rand_span(-LON_MAX, LON_MAX), rand_span(-LAT_MAX, LAT_MAX),
				$urandom_range(16384, 4194304), $urandom_range(16384, 4194304),
				$urandom_range(2, 9), $urandom_range(2, 9)};
		endcase
		loaded_cols = (v[CFG_LON_LINES] * v[CFG_LAT_POINTS] > 200) ? 2 : v[CFG_LON_LINES];
	endtask

	task automatic run_phase(input int n);
		longint v[6];
		int cols;
		int pts;
		stim_row_t s;
		height_rec_t r;
		bit ok;
		pick_phase(n, v, cols);
		write_regs(v);
		pts = sh_lat_points;
		s = '{default: 0};
		s.op = OP_LOAD;
		for (int c = 0; c < cols; c++)
			for (int p = 0; p < pts; p++) begin
				s.idx = ADDR_W'(c * pts + p);
				s.word = rand_post_word();
				s.lon = rand_span(-LON_MAX, LON_MAX);
				s.lat = rand_span(-LAT_MAX, LAT_MAX);
				send_item(s);
			end
		repeat (RANDOM_OPS) begin
			s.op = ($urandom_range(0, 3) == 0) ? OP_LOAD : OP_QUERY;
			s.idx = POST_W'($urandom);
			s.word = rand_post_word();
			ok = 1'b0;
			if (s.op == OP_QUERY) begin
				for (int t = 0; t < 20 && !ok; t++) begin
					s.lon = pick_coord(sh_corner_lon, sh_lon_ppd, cols - 1, LON_MAX);
					s.lat = pick_coord(sh_corner_lat, sh_lat_ppd, pts - 1, LAT_MAX);
					ok = interp_height(s.lon, s.lat, r);
				end
				// no legal point found: send a load instead
				if (!ok)
					s.op = OP_LOAD;
			end
			if (s.op == OP_LOAD && $urandom_range(0, 2) != 0)
				s.idx = ADDR_W'($urandom_range(0, cols * pts - 1));
			send_item(s);
		end
		wait_idle();
	endtask

	// Directed rows, run with the reset defaults: corner at the origin, one post
	// per degree (1.0 deg = 4194304 in Q9.22), 2x2 grid.
	stim_row_t directed[$];

	initial begin
		for (int i = 0; i < POST_DEPTH; i++)
			post_set[i] = 1'b0;
		sh_corner_lon = '0;
		sh_corner_lat = '0;
		sh_lon_ppd    = 65536;
		sh_lat_ppd    = 65536;
		sh_lon_lines  = 2;
		sh_lat_points = 2;

		directed = '{
			// load posts; query fields ignored on a load
			'{OP_LOAD,  16'd0, 16'h0064, 123, -5, 0, 0, 0},
			'{OP_LOAD,  16'd1, 16'h8000, 0, 0, 0, 0, 0},
			'{OP_LOAD,  16'd2, VOID_POST, 0, 0, 0, 0, 0},
			'{OP_LOAD,  16'd3, 16'h7FFF, 0, 0, 0, 0, 0},
			// southwest post alone; load fields ignored on a query
			'{OP_QUERY, 16'hFFFF, 16'hFFFF, 0, 0, 1, 24'sd25600, 0},
			// right edge lands on a null post: nothing weighted
			'{OP_QUERY, 16'd0, 16'd0, 4194304, 0, 1, 24'sd0, 1},
			// negative zero post
			'{OP_QUERY, 16'd0, 16'd0, 0, 4194304, 1, 24'sd0, 0},
			// top right corner, largest magnitude
			'{OP_QUERY, 16'd0, 16'd0, 4194304, 4194304, 1, 24'sd8388352, 0},
			// outside on each side
			'{OP_QUERY, 16'd0, 16'd0, -1, 0, 1, 24'sd0, 1},
			'{OP_QUERY, 16'd0, 16'd0, 0, -1, 1, 24'sd0, 1},
			'{OP_QUERY, 16'd0, 16'd0, 4194368, 0, 1, 24'sd0, 1},
			'{OP_QUERY, 16'd0, 16'd0, 0, 4194368, 1, 24'sd0, 1},
			'{OP_QUERY, 16'd0, 16'd0, LON_MAX, LAT_MAX, 1, 24'sd0, 1},
			'{OP_QUERY, 16'd0, 16'd0, -LON_MAX, -LAT_MAX, 1, 24'sd0, 1},
			// negative post
			'{OP_LOAD,  16'd0, 16'h8005, 0, 0, 0, 0, 0},
			'{OP_QUERY, 16'd0, 16'd0, 0, 0, 1, -24'sd1280, 0},
			'{OP_QUERY, 16'd0, 16'd0, 2097152, 2097152, 0, 0, 0},
			'{OP_QUERY, 16'd0, 16'd0, 1234567, 3456789, 0, 0, 0},
			// all weight on a null post, the rest weighted zero
			'{OP_LOAD,  16'd1, VOID_POST, 0, 0, 0, 0, 0},
			'{OP_QUERY, 16'd0, 16'd0, 0, 4194304, 1, 24'sd0, 1},
			// top index, stray index
			'{OP_LOAD,  16'hFFFF, VOID_POST, -LON_MAX, -LAT_MAX, 0, 0, 0},
			'{OP_LOAD,  16'h1234, 16'h5A5A, LON_MAX, LAT_MAX, 0, 0, 0},
			// two of the four posts null, weights renormalized over the others
			'{OP_QUERY, 16'd0, 16'd0, 1048576, 3145728, 0, 0, 0}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_item(directed[i]);
		wait_idle();

		for (int ph = 1; ph <= 9; ph++)
			run_phase(ph);

		if (heights_due.size() != 0)
			note_mismatch($sformatf("%0d results never arrived", heights_due.size()));

		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
